// ===== rtl/core/wde_pkg.sv =====
package wde_pkg;

  localparam int unsigned TOKEN_W = 31;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned WALKS_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WALKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [WALKS_W-1:0] WALKS_RESET = 8'd100;
  localparam logic [STEP_W-1:0]  STEPS_RESET = 4'd3;

  typedef struct packed {
    logic               cmd;
    logic [TOKEN_W-1:0] token;
    logic [ROW_W-1:0]   row_index;
    logic [STEP_W-1:0]  step_index;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   distinct_total;
    logic [TOKEN_W-1:0] node_key;
    logic [COUNT_W-1:0] step_count;
    logic               read_invalid;
  } out_t;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'h001,
    ST_RD_WAIT = 12'h002,
    ST_B_INIT  = 12'h004,
    ST_CLR     = 12'h008,
    ST_T_RD    = 12'h010,
    ST_T_WAIT  = 12'h020,
    ST_S_RD    = 12'h040,
    ST_S_CMP   = 12'h080,
    ST_BUMP_RD = 12'h100,
    ST_BUMP_WR = 12'h200,
    ST_NEXT    = 12'h400,
    ST_DONE    = 12'h800
  } state_e;

endpackage

// ===== rtl/core/wde_ram.sv =====
module wde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/walk_distance_encoder.sv =====
// channel | dir | handshake             | beat
// in      | in  | in_valid_i/in_ready_o | wde_pkg::in_t: push token or read entry
// out     | out | out_valid_o/out_ready_i | wde_pkg::out_t: build notice or answer
// cfg     | in  | cfg_valid_i/cfg_ready_o | register index and write data
// A push that does not complete the set stays in idle; a read goes through ST_RD_WAIT.
// A build runs over the walk buffer: per token a buffer read, then a node-table
// search entry by entry (one table port, linear key search), then a count bump;
// all STEPS_MAX+1 entries of the count row of each new node and of the root are cleared.
// No clearing pass after reset; counts read as zero until the first build.
// Input is taken in idle while the output register is free or being drained.
module walk_distance_encoder #(
  parameter int unsigned WALKS_MAX = 128,
  parameter int unsigned STEPS_MAX = 8,
  parameter int unsigned NODE_BITS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wde_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output wde_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wde_pkg::WALKS_W-1:0]       cfg_data_i
);

  import wde_pkg::*;

  localparam int unsigned STRIDE    = STEPS_MAX + 1;
  localparam int unsigned BUF_DEPTH = WALKS_MAX * STRIDE;
  localparam int unsigned TAB_DEPTH = 1 + WALKS_MAX * STEPS_MAX;
  localparam int unsigned CNT_DEPTH = TAB_DEPTH * STRIDE;
  localparam int unsigned BA  = $clog2(BUF_DEPTH);
  localparam int unsigned TOW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned TA  = $clog2(TAB_DEPTH);
  localparam int unsigned TW  = $clog2(TAB_DEPTH + 1);
  localparam int unsigned CA  = $clog2(CNT_DEPTH);
  localparam int unsigned SW  = $clog2(STEPS_MAX + 1);
  localparam int unsigned WW  = $clog2(WALKS_MAX + 1);
  localparam int unsigned BSTEPS_RST = (STEPS_MAX < 3) ? STEPS_MAX : 3;

  state_e state_q, state_d;
  logic [WALKS_W-1:0] walks_cfg_q, walks_cfg_d;
  logic [STEP_W-1:0]  steps_cfg_q, steps_cfg_d;
  logic [BA-1:0] load_q, load_d;
  logic [NODE_BITS-1:0] root_q, root_d;
  logic [TW-1:0] n_q, n_d;
  logic built_q, built_d;
  logic [SW-1:0] bsteps_q, bsteps_d;
  logic [SW-1:0] i_q, i_d;
  logic [WW-1:0] j_q, j_d;
  logic [WW-1:0] walks_q, walks_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [BA-1:0] baddr_q, baddr_d;
  logic [NODE_BITS-1:0] key_q, key_d;
  logic [TA-1:0] k_q, k_d;
  logic [TA-1:0] hit_q, hit_d;
  logic [SW-1:0] clr_q, clr_d;
  logic rd_bad_q, rd_bad_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic [WW-1:0] walks_eff;
  logic [SW-1:0] steps_eff;
  logic [TOW-1:0] total;
  logic in_acc;
  logic rd_bad;
  logic [TA-1:0] row_a;

  logic buf_we;
  logic [NODE_BITS-1:0] buf_wdata, buf_rdata, token_key;
  logic tab_we;
  logic [TA-1:0] tab_waddr, tab_raddr;
  logic [NODE_BITS-1:0] tab_wdata, tab_rdata;
  logic cnt_we;
  logic [CA-1:0] cnt_waddr, cnt_raddr, rd_caddr, bump_caddr, clr_caddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  always_comb begin
    if (walks_cfg_q == '0) begin
      walks_eff = WW'(1);
    end else if (walks_cfg_q > WALKS_MAX) begin
      walks_eff = WW'(WALKS_MAX);
    end else begin
      walks_eff = WW'(walks_cfg_q);
    end
    if (steps_cfg_q == '0) begin
      steps_eff = SW'(1);
    end else if (steps_cfg_q > STEPS_MAX) begin
      steps_eff = SW'(STEPS_MAX);
    end else begin
      steps_eff = SW'(steps_cfg_q);
    end
  end

  assign total = TOW'(walks_eff) * (TOW'(steps_eff) + TOW'(1));
  assign token_key = NODE_BITS'(in_data_i.token);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_bad = (in_data_i.row_index >= n_q) || (in_data_i.step_index > bsteps_q)
               || (in_data_i.row_index >= TAB_DEPTH);
  assign row_a  = rd_bad ? '0 : TA'(in_data_i.row_index);
  assign rd_caddr   = CA'(row_a) * CA'(STRIDE) + (rd_bad ? CA'(0) : CA'(in_data_i.step_index));
  assign bump_caddr = CA'(hit_q) * CA'(STRIDE) + CA'(i_q);
  assign clr_caddr  = CA'(hit_q) * CA'(STRIDE) + CA'(clr_q);

  assign buf_we    = in_acc && (in_data_i.cmd == CMD_PUSH);
  assign buf_wdata = token_key;
  assign tab_raddr = (state_q == ST_S_RD) ? k_q : row_a;
  assign cnt_raddr = (state_q == ST_BUMP_RD) ? bump_caddr : rd_caddr;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = '0;
    tab_wdata = root_q;
    cnt_we    = 1'b0;
    cnt_waddr = clr_caddr;
    cnt_wdata = '0;
    if (state_q == ST_B_INIT) begin
      tab_we = 1'b1;
    end
    if (state_q == ST_S_CMP && tab_rdata != key_q && (TW'(k_q) + TW'(1)) == n_q
        && n_q < TW'(TAB_DEPTH)) begin
      tab_we    = 1'b1;
      tab_waddr = TA'(n_q);
      tab_wdata = key_q;
    end
    if (state_q == ST_CLR) begin
      cnt_we = 1'b1;
      if (hit_q == '0 && clr_q == '0) begin
        cnt_wdata = COUNT_W'(walks_q);
      end
    end
    if (state_q == ST_BUMP_WR) begin
      cnt_we    = 1'b1;
      cnt_waddr = bump_caddr;
      cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_W'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    walks_cfg_d = walks_cfg_q;
    steps_cfg_d = steps_cfg_q;
    load_d      = load_q;
    root_d      = root_q;
    n_d         = n_q;
    built_d     = built_q;
    bsteps_d    = bsteps_q;
    i_d         = i_q;
    j_d         = j_q;
    walks_d     = walks_q;
    steps_d     = steps_q;
    baddr_d     = baddr_q;
    key_d       = key_q;
    k_d         = k_q;
    hit_d       = hit_q;
    clr_d       = clr_q;
    rd_bad_d    = rd_bad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WALKS) begin
        walks_cfg_d = cfg_data_i;
      end else if (cfg_index_i == CFG_STEPS) begin
        steps_cfg_d = cfg_data_i[STEP_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.cmd == CMD_READ) begin
            rd_bad_d = rd_bad;
            state_d  = ST_RD_WAIT;
          end else begin
            if (load_q == '0) begin
              root_d = token_key;
            end
            if ((TOW'(load_q) + TOW'(1)) < total) begin
              load_d = load_q + BA'(1);
            end else begin
              load_d  = '0;
              walks_d = walks_eff;
              steps_d = steps_eff;
              state_d = ST_B_INIT;
            end
          end
        end
      end
      ST_RD_WAIT: begin
        out_valid_d          = 1'b1;
        out_d.kind           = KIND_READ;
        out_d.distinct_total = ROW_W'(n_q);
        out_d.read_invalid   = rd_bad_q;
        out_d.node_key       = rd_bad_q ? '0 : TOKEN_W'(tab_rdata);
        out_d.step_count     = (rd_bad_q || !built_q) ? '0 : cnt_rdata;
        state_d              = ST_IDLE;
      end
      ST_B_INIT: begin
        n_d     = TW'(1);
        hit_d   = '0;
        clr_d   = '0;
        state_d = ST_CLR;
      end
      ST_CLR: begin
        clr_d = clr_q + SW'(1);
        if (clr_q == SW'(STEPS_MAX)) begin
          if (hit_q == '0) begin
            i_d     = SW'(1);
            j_d     = '0;
            baddr_d = BA'(1);
            state_d = ST_T_RD;
          end else begin
            state_d = ST_BUMP_RD;
          end
        end
      end
      ST_T_RD: begin
        state_d = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        key_d   = buf_rdata;
        k_d     = '0;
        state_d = ST_S_RD;
      end
      ST_S_RD: begin
        state_d = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (tab_rdata == key_q) begin
          hit_d   = k_q;
          state_d = ST_BUMP_RD;
        end else if ((TW'(k_q) + TW'(1)) == n_q) begin
          if (n_q < TW'(TAB_DEPTH)) begin
            hit_d   = TA'(n_q);
            n_d     = n_q + TW'(1);
            clr_d   = '0;
            state_d = ST_CLR;
          end else begin
            state_d = ST_NEXT;
          end
        end else begin
          k_d     = k_q + TA'(1);
          state_d = ST_S_RD;
        end
      end
      ST_BUMP_RD: begin
        state_d = ST_BUMP_WR;
      end
      ST_BUMP_WR: begin
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if ((j_q + WW'(1)) < walks_q) begin
          j_d     = j_q + WW'(1);
          baddr_d = baddr_q + BA'(steps_q) + BA'(1);
          state_d = ST_T_RD;
        end else if (i_q < steps_q) begin
          i_d     = i_q + SW'(1);
          j_d     = '0;
          baddr_d = BA'(i_q) + BA'(1);
          state_d = ST_T_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        built_d              = 1'b1;
        bsteps_d             = steps_q;
        out_valid_d          = 1'b1;
        out_d.kind           = KIND_BUILD;
        out_d.distinct_total = ROW_W'(n_q);
        out_d.node_key       = TOKEN_W'(root_q);
        out_d.step_count     = COUNT_W'(walks_q);
        out_d.read_invalid   = 1'b0;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walks_cfg_q <= WALKS_RESET;
      steps_cfg_q <= STEPS_RESET;
      load_q      <= '0;
      n_q         <= TW'(1);
      built_q     <= 1'b0;
      bsteps_q    <= SW'(BSTEPS_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walks_cfg_q <= walks_cfg_d;
      steps_cfg_q <= steps_cfg_d;
      load_q      <= load_d;
      n_q         <= n_d;
      built_q     <= built_d;
      bsteps_q    <= bsteps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q   <= root_d;
    i_q      <= i_d;
    j_q      <= j_d;
    walks_q  <= walks_d;
    steps_q  <= steps_d;
    baddr_q  <= baddr_d;
    key_q    <= key_d;
    k_q      <= k_d;
    hit_q    <= hit_d;
    clr_q    <= clr_d;
    rd_bad_q <= rd_bad_d;
    out_q    <= out_d;
  end

  wde_ram #(.WIDTH(NODE_BITS), .DEPTH(BUF_DEPTH)) u_walk_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (load_q),
    .wdata_i (buf_wdata),
    .raddr_i (baddr_q),
    .rdata_o (buf_rdata)
  );

  wde_ram #(.WIDTH(NODE_BITS), .DEPTH(TAB_DEPTH)) u_node_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  wde_ram #(.WIDTH(COUNT_W), .DEPTH(CNT_DEPTH)) u_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

`ifndef SYNTHESIS
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_o && out_data_o.kind == KIND_BUILD)
    else $error("build end without notice");

  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD_WAIT |=> out_valid_o && out_data_o.kind == KIND_READ)
    else $error("read without answer");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_S_CMP |-> TW'(k_q) < n_q)
    else $error("search beyond table fill");
`endif

endmodule

// ===== verif/walk_distance_encoder_tb.sv =====
module walk_distance_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wde_pkg::*;

  localparam int unsigned WALKS_MAX = 128;
  localparam int unsigned STEPS_MAX = 8;
  localparam int unsigned BUF_DEPTH = WALKS_MAX * (STEPS_MAX + 1);
  localparam int unsigned TAB_DEPTH = 1 + WALKS_MAX * STEPS_MAX;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  class walk_table_scoreboard;
    logic [TOKEN_W-1:0] walk_buf [BUF_DEPTH];
    logic [TOKEN_W-1:0] node_tab [TAB_DEPTH];
    logic [COUNT_W-1:0] node_cnt [TAB_DEPTH][STEPS_MAX+1];
    int unsigned distinct;
    int unsigned load_pos;
    int unsigned built_steps;
    logic [WALKS_W-1:0] walks_reg;
    logic [STEP_W-1:0] steps_reg;
    out_t answers[$];
    int errors;

    function new();
      distinct = 1;
      load_pos = 0;
      walks_reg = WALKS_RESET;
      steps_reg = STEPS_RESET;
      built_steps = STEPS_RESET;
      errors = 0;
    endfunction

    function int unsigned walks_eff();
      if (walks_reg < 1) return 1;
      if (walks_reg > WALKS_MAX) return WALKS_MAX;
      return walks_reg;
    endfunction

    function int unsigned steps_eff();
      if (steps_reg < 1) return 1;
      if (steps_reg > STEPS_MAX) return STEPS_MAX;
      return steps_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WALKS_W-1:0] val);
      if (idx == CFG_WALKS) walks_reg = val;
      else if (idx == CFG_STEPS) steps_reg = val[STEP_W-1:0];
    endfunction

    function void build(int unsigned w, int unsigned s);
      int unsigned n;
      int unsigned hit;
      logic [TOKEN_W-1:0] key;
      n = 1;
      for (int r = 0; r < TAB_DEPTH; r++)
        for (int c = 0; c <= STEPS_MAX; c++) node_cnt[r][c] = '0;
      node_tab[0] = walk_buf[0];
      node_cnt[0][0] = COUNT_W'(w);
      for (int i = 1; i <= s; i++) begin
        for (int j = 0; j < w; j++) begin
          key = walk_buf[j * (s + 1) + i];
          hit = n;
          for (int k = 0; k < n; k++) begin
            if (node_tab[k] == key) begin
              hit = k;
              break;
            end
          end
          if (hit == n && n < TAB_DEPTH) begin
            node_tab[n] = key;
            n++;
          end
          if (hit < TAB_DEPTH && node_cnt[hit][i] != 8'hFF) node_cnt[hit][i]++;
        end
      end
      distinct = n;
      built_steps = s;
    endfunction

    function void note_beat(in_t b);
      out_t o;
      int unsigned w, s;
      if (b.cmd == CMD_PUSH) begin
        w = walks_eff();
        s = steps_eff();
        if (load_pos < BUF_DEPTH) walk_buf[load_pos] = b.token;
        if (load_pos + 1 < w * (s + 1)) begin
          load_pos++;
          return;
        end
        load_pos = 0;
        build(w, s);
        o.kind = KIND_BUILD;
        o.distinct_total = ROW_W'(distinct);
        o.node_key = node_tab[0];
        o.step_count = node_cnt[0][0];
        o.read_invalid = 1'b0;
      end else begin
        o.kind = KIND_READ;
        o.distinct_total = ROW_W'(distinct);
        if (b.row_index >= distinct || b.step_index > built_steps) begin
          o.node_key = '0;
          o.step_count = '0;
          o.read_invalid = 1'b1;
        end else begin
          o.node_key = node_tab[b.row_index];
          o.step_count = node_cnt[b.row_index][b.step_index];
          o.read_invalid = 1'b0;
        end
      end
      answers.push_back(o);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_beat(out_t got);
      out_t want;
      if (answers.size() == 0) begin
        report("unexpected beat", got, 0);
        return;
      end
      want = answers.pop_front();
      if (got.kind != want.kind) report("kind", got.kind, want.kind);
      if (got.distinct_total != want.distinct_total)
        report("distinct_total", got.distinct_total, want.distinct_total);
      if (got.node_key != want.node_key) report("node_key", got.node_key, want.node_key);
      if (got.step_count != want.step_count)
        report("step_count", got.step_count, want.step_count);
      if (got.read_invalid != want.read_invalid)
        report("read_invalid", got.read_invalid, want.read_invalid);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_valid_i, cfg_ready_o;
  in_t in_data_i;
  out_t out_data_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WALKS_W-1:0] cfg_data_i;

  walk_distance_encoder uut (.*);

  walk_table_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_left, beats_sent;
  int unsigned cycles;
  logic [TOKEN_W-1:0] pool[16];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_data_o);

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task send_beat(in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(b);
    beats_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task push_token(logic [TOKEN_W-1:0] tok);
    in_t b;
    b = '0;
    b.cmd = CMD_PUSH;
    b.token = tok;
    b.row_index = ROW_W'($urandom);
    b.step_index = STEP_W'($urandom);
    send_beat(b);
  endtask

  task read_entry(int unsigned row, int unsigned st);
    in_t b;
    b.cmd = CMD_READ;
    b.token = TOKEN_W'($urandom);
    b.row_index = ROW_W'(row);
    b.step_index = STEP_W'(st);
    send_beat(b);
  endtask

  task wait_drained();
    while (sb.answers.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [WALKS_W-1:0] val);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task random_read();
    if ($urandom_range(3) == 0)
      read_entry($urandom_range(2047), $urandom_range(15));
    else
      read_entry($urandom_range(sb.distinct + 1), $urandom_range(sb.built_steps + 1));
  endtask

  task push_set(int pool_n, int noise_pct);
    int unsigned total;
    for (int k = 0; k < pool_n; k++) pool[k] = TOKEN_W'($urandom);
    total = sb.walks_eff() * (sb.steps_eff() + 1);
    for (int t = 0; t < total; t++) begin
      if (sb.distinct > 1 && $urandom_range(99) < noise_pct) random_read();
      push_token(pool[$urandom_range(pool_n - 1)]);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    beats_sent = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WALKS;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    read_entry(1, 0);
    read_entry(0, 9);
    read_entry(2047, 15);
    write_reg(CFG_WALKS, 8'd1);
    write_reg(CFG_STEPS, 8'd1);
    push_token('0);
    push_token('1);
    read_entry(0, 0);
    read_entry(1, 1);
    read_entry(2, 0);
    read_entry(0, 2);
    write_reg(CFG_WALKS, 8'd0);
    write_reg(CFG_STEPS, 8'hF0);
    push_token(31'h2AAAAAAA);
    push_token(31'h55555555);
    read_entry(1, 1);
    write_reg(CFG_WALKS, 8'd2);
    write_reg(CFG_STEPS, 8'd1);
    push_token(31'h12345);
    push_token(31'h12345);
    write_reg(CFG_WALKS, 8'd1);
    push_token(31'h777);
    read_entry(0, 0);
    read_entry(0, 1);

    for (int set_no = 0; beats_sent < 1150; set_no++) begin
      case ((set_no / 3) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (set_no == 3) begin
        write_reg(CFG_WALKS, 8'd255);
        write_reg(CFG_STEPS, 8'd2);
        push_set(4, 0);
      end else if (set_no == 7) begin
        write_reg(CFG_WALKS, 8'd128);
        write_reg(CFG_STEPS, 8'd1);
        push_set(16, 2);
      end else if (set_no == 9) begin
        write_reg(CFG_WALKS, 8'd3);
        write_reg(CFG_STEPS, 8'd15);
        push_set(12, 5);
      end else begin
        write_reg(CFG_WALKS, WALKS_W'($urandom_range(6)));
        write_reg(CFG_STEPS, WALKS_W'($urandom_range(9)));
        push_set($urandom_range(1, 12), 10);
      end
      if (set_no == 5) begin
        hold_left = 400;
        repeat (30) random_read();
      end else begin
        repeat ($urandom_range(3, 8)) random_read();
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
